@@ src/msr_pkg.sv @@
package msr_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int PERIOD_BITS = 16;
    localparam int FIXED_W     = PERIOD_BITS + FRAC_BITS;
    localparam int CFG_W       = 16;
    localparam int DIV_CNT_W   = $clog2(FIXED_W);
    localparam int PC_W        = 5;
    localparam int ADDR_W      = 5;

    localparam logic [2:0] CFG_START_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_SAFE_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_MIN_PERIOD    = 3'd2;
    localparam logic [2:0] CFG_DECAY_DIVISOR = 3'd3;
    localparam logic [2:0] CFG_HOLD_COUNT    = 3'd4;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_CONT = 2'd1;
    localparam logic [1:0] ST_HAND = 2'd2;
    localparam logic [1:0] ST_GIVE = 2'd3;

    typedef enum logic {
        PH_IDLE,
        PH_RUN
    } phase_t;

    typedef struct packed {
        logic [1:0] func;
        logic       spin_ready;
    } in_item_t;

    typedef struct packed {
        logic        commutate;
        logic [1:0]  status;
        logic [15:0] period_now;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_RELOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SUB,
        OP_CLAMP,
        OP_HOLD_DEC,
        OP_GIVE,
        OP_HAND,
        OP_CONT,
        OP_TICK_DEC,
        OP_START,
        OP_STOP,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_FUNC_START,
        C_FUNC_STOP,
        C_NOT_RUN_TICK,
        C_TICK_GT1,
        C_HANDOFF,
        C_DIV_MORE,
        C_ABOVE_MIN,
        C_HOLD_ZERO,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic init;
        logic step;
    } div_ctl_t;

    localparam logic [PC_W-1:0] S_FETCH    = 5'd0;
    localparam logic [PC_W-1:0] S_DISP     = 5'd1;
    localparam logic [PC_W-1:0] S_CHK_STOP = 5'd2;
    localparam logic [PC_W-1:0] S_CHK_RUN  = 5'd3;
    localparam logic [PC_W-1:0] S_CHK_TICK = 5'd4;
    localparam logic [PC_W-1:0] S_RELOAD   = 5'd5;
    localparam logic [PC_W-1:0] S_DIV_INIT = 5'd6;
    localparam logic [PC_W-1:0] S_DIV      = 5'd7;
    localparam logic [PC_W-1:0] S_SUB      = 5'd8;
    localparam logic [PC_W-1:0] S_CHK_MIN  = 5'd9;
    localparam logic [PC_W-1:0] S_CLAMP    = 5'd10;
    localparam logic [PC_W-1:0] S_HOLD     = 5'd11;
    localparam logic [PC_W-1:0] S_GIVE     = 5'd12;
    localparam logic [PC_W-1:0] S_HAND     = 5'd13;
    localparam logic [PC_W-1:0] S_CONT     = 5'd14;
    localparam logic [PC_W-1:0] S_TDEC     = 5'd15;
    localparam logic [PC_W-1:0] S_START    = 5'd16;
    localparam logic [PC_W-1:0] S_STOP     = 5'd17;
    localparam logic [PC_W-1:0] S_EMIT     = 5'd18;
    localparam logic [PC_W-1:0] S_RETRY    = 5'd19;

    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            S_FETCH:    w = '{OP_FETCH,    C_NO_INPUT,     S_FETCH};
            S_DISP:     w = '{OP_NOP,      C_FUNC_START,   S_START};
            S_CHK_STOP: w = '{OP_NOP,      C_FUNC_STOP,    S_STOP};
            S_CHK_RUN:  w = '{OP_NOP,      C_NOT_RUN_TICK, S_EMIT};
            S_CHK_TICK: w = '{OP_NOP,      C_TICK_GT1,     S_TDEC};
            S_RELOAD:   w = '{OP_RELOAD,   C_HANDOFF,      S_HAND};
            S_DIV_INIT: w = '{OP_DIV_INIT, C_NEVER,        S_FETCH};
            S_DIV:      w = '{OP_DIV_STEP, C_DIV_MORE,     S_DIV};
            S_SUB:      w = '{OP_SUB,      C_NEVER,        S_FETCH};
            S_CHK_MIN:  w = '{OP_NOP,      C_ABOVE_MIN,    S_CONT};
            S_CLAMP:    w = '{OP_CLAMP,    C_HOLD_ZERO,    S_GIVE};
            S_HOLD:     w = '{OP_HOLD_DEC, C_ALWAYS,       S_EMIT};
            S_GIVE:     w = '{OP_GIVE,     C_ALWAYS,       S_EMIT};
            S_HAND:     w = '{OP_HAND,     C_ALWAYS,       S_EMIT};
            S_CONT:     w = '{OP_CONT,     C_ALWAYS,       S_EMIT};
            S_TDEC:     w = '{OP_TICK_DEC, C_ALWAYS,       S_EMIT};
            S_START:    w = '{OP_START,    C_ALWAYS,       S_EMIT};
            S_STOP:     w = '{OP_STOP,     C_ALWAYS,       S_EMIT};
            S_EMIT:     w = '{OP_EMIT,     C_OUT_FREE,     S_FETCH};
            S_RETRY:    w = '{OP_NOP,      C_ALWAYS,       S_EMIT};
            default:    w = '{OP_NOP,      C_ALWAYS,       S_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic [PERIOD_BITS-1:0] to_per(input logic [CFG_W-1:0] v);
        logic [PERIOD_BITS+CFG_W-1:0] t;
        t = {{PERIOD_BITS{1'b0}}, v};
        return t[PERIOD_BITS-1:0];
    endfunction

    function automatic logic [15:0] to16(input logic [PERIOD_BITS-1:0] p);
        logic [PERIOD_BITS+15:0] t;
        t = {16'd0, p};
        return t[15:0];
    endfunction

endpackage

@@ src/motor_spinup_commutation_ramp.sv @@
// Channel   Ports                     Carries
// input     s_valid s_ready s_data    func, spin_ready
// result    m_valid m_ready m_data    commutate, status, period_now
// config    APB psel..prdata          five 16-bit registers at 4*i
// One item at a time. A commutating tick that does not hand off runs the 32-step
// shift-subtract divider of period/divisor, then may clamp to the minimum period.
// A finished result sits in the output register; the next item is taken meanwhile.
// A stalled m_ready holds the sequencer at the emit and retry steps only.
// Reset (aresetn low, synchronous) loads register defaults and idles the ramp.
module motor_spinup_commutation_ramp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  msr_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output msr_pkg::out_item_t           m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import msr_pkg::*;

    logic [CFG_W-1:0] start_period_reg, safe_period_reg, min_period_reg;
    logic [CFG_W-1:0] decay_divisor_reg, hold_count_reg;

    logic [PC_W-1:0]    pc_reg, pc_next;
    phase_t             phase_reg, phase_next;
    logic [FIXED_W-1:0] period_reg, period_next;
    logic [15:0]        hold_reg, hold_next;
    logic [15:0]        tick_reg, tick_next;
    logic [1:0]         func_reg, func_next;
    logic               rdy_reg, rdy_next;
    logic               comm_reg, comm_next;
    logic [1:0]         status_reg, status_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    ucode_t                 cw;
    logic                   take;
    logic                   cfg_wr;
    logic [2:0]             cfg_idx;
    logic [PERIOD_BITS-1:0] whole;
    logic [PERIOD_BITS-1:0] minp;
    logic [FIXED_W-1:0]     safe_fx;
    logic                   out_free;
    div_ctl_t               div_ctl;
    logic [CFG_W-1:0]       div_dv;
    logic [FIXED_W-1:0]     div_quo;
    logic                   div_last;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_period_reg  <= 16'd1000;
            safe_period_reg   <= 16'd100;
            min_period_reg    <= 16'd20;
            decay_divisor_reg <= 16'd64;
            hold_count_reg    <= 16'd0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_START_PERIOD:  start_period_reg  <= pwdata[CFG_W-1:0];
                CFG_SAFE_PERIOD:   safe_period_reg   <= pwdata[CFG_W-1:0];
                CFG_MIN_PERIOD:    min_period_reg    <= pwdata[CFG_W-1:0];
                CFG_DECAY_DIVISOR: decay_divisor_reg <= pwdata[CFG_W-1:0];
                CFG_HOLD_COUNT:    hold_count_reg    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_START_PERIOD:  prdata = {16'd0, start_period_reg};
            CFG_SAFE_PERIOD:   prdata = {16'd0, safe_period_reg};
            CFG_MIN_PERIOD:    prdata = {16'd0, min_period_reg};
            CFG_DECAY_DIVISOR: prdata = {16'd0, decay_divisor_reg};
            CFG_HOLD_COUNT:    prdata = {16'd0, hold_count_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign whole    = period_reg[FIXED_W-1:FRAC_BITS];
    assign minp     = to_per(min_period_reg);
    assign safe_fx  = {to_per(safe_period_reg), {FRAC_BITS{1'b0}}};
    assign div_dv   = (decay_divisor_reg == '0) ? CFG_W'(1) : decay_divisor_reg;
    assign out_free = !m_valid_reg || m_ready;

    msr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (period_reg),
        .divisor  (div_dv),
        .quotient (div_quo),
        .last     (div_last)
    );

    // sequencer
    assign cw      = ucode(pc_reg);
    assign s_ready = pc_reg == S_FETCH;

    always_comb begin
        case (cw.cond)
            C_NEVER:        take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NO_INPUT:     take = !s_valid;
            C_FUNC_START:   take = func_reg == FUNC_START;
            C_FUNC_STOP:    take = func_reg == FUNC_STOP;
            C_NOT_RUN_TICK: take = !(func_reg == FUNC_TICK && phase_reg == PH_RUN);
            C_TICK_GT1:     take = tick_reg > 16'd1;
            C_HANDOFF:      take = rdy_reg && (period_reg < safe_fx);
            C_DIV_MORE:     take = !div_last;
            C_ABOVE_MIN:    take = whole > minp;
            C_HOLD_ZERO:    take = hold_reg == 16'd0;
            C_OUT_FREE:     take = out_free;
            default:        take = 1'b0;
        endcase
        pc_next = take ? cw.target : pc_reg + 1'b1;
    end

    // datapath
    always_comb begin
        phase_next   = phase_reg;
        period_next  = period_reg;
        hold_next    = hold_reg;
        tick_next    = tick_reg;
        func_next    = func_reg;
        rdy_next     = rdy_reg;
        comm_next    = comm_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        div_ctl      = '{init: 1'b0, step: 1'b0};
        case (cw.op)
            OP_FETCH: begin
                if (s_valid) begin
                    func_next   = s_data.func;
                    rdy_next    = s_data.spin_ready;
                    comm_next   = 1'b0;
                    status_next = ST_NONE;
                end
            end
            OP_RELOAD: begin
                comm_next = 1'b1;
                tick_next = to16(whole);
            end
            OP_DIV_INIT: div_ctl.init = 1'b1;
            OP_DIV_STEP: div_ctl.step = 1'b1;
            OP_SUB:      period_next = period_reg - div_quo;
            OP_CLAMP:    period_next = {minp, {FRAC_BITS{1'b0}}};
            OP_HOLD_DEC: begin
                hold_next   = hold_reg - 16'd1;
                status_next = ST_CONT;
            end
            OP_GIVE: begin
                status_next = ST_GIVE;
                phase_next  = PH_IDLE;
            end
            OP_HAND: begin
                status_next = ST_HAND;
                phase_next  = PH_IDLE;
            end
            OP_CONT:     status_next = ST_CONT;
            OP_TICK_DEC: tick_next = tick_reg - 16'd1;
            OP_START: begin
                period_next = {to_per(start_period_reg), {FRAC_BITS{1'b0}}};
                hold_next   = hold_count_reg;
                tick_next   = to16(to_per(start_period_reg));
                phase_next  = PH_RUN;
            end
            OP_STOP:     phase_next = PH_IDLE;
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{commutate: comm_reg, status: status_reg,
                                     period_now: to16(whole)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= S_FETCH;
            phase_reg   <= PH_IDLE;
            period_reg  <= '0;
            hold_reg    <= '0;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            phase_reg   <= phase_next;
            period_reg  <= period_next;
            hold_reg    <= hold_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg   <= func_next;
        rdy_reg    <= rdy_next;
        comm_reg   <= comm_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer accepted while an item is in work");

    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(pc_reg) == S_EMIT)
        else $error("result loaded outside the emit step");

    a_comm_decides: assert property (@(posedge aclk) disable iff (!aresetn)
        cw.op == OP_EMIT && comm_reg |-> status_reg != ST_NONE)
        else $error("commutation emitted without a decision");

    a_end_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        cw.op == OP_EMIT && (status_reg == ST_HAND || status_reg == ST_GIVE)
            |-> phase_reg == PH_IDLE)
        else $error("hand off or give up left the ramp running");

endmodule

@@ src/msr_div.sv @@
module msr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  msr_pkg::div_ctl_t             ctl,
    input  logic [msr_pkg::FIXED_W-1:0]   dividend,
    input  logic [msr_pkg::CFG_W-1:0]     divisor,
    output logic [msr_pkg::FIXED_W-1:0]   quotient,
    output logic                          last
);
    import msr_pkg::*;

    logic [CFG_W-1:0]     rem_reg, rem_next;
    logic [FIXED_W-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W:0]       trial;
    logic [CFG_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[FIXED_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};
    assign last  = cnt_reg == DIV_CNT_W'(FIXED_W - 1);
    assign quotient = quo_reg;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (ctl.init) begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = '0;
        end else if (ctl.step) begin
            rem_next = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            quo_next = {quo_reg[FIXED_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import msr_pkg::*;

    localparam logic [1:0] FUNC_RSVD  = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int N_PHASES   = 12;
    localparam int PHASE_ITEMS = 125;
    localparam int LONG_STALL = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE     = 60;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    motor_spinup_commutation_ramp uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ramp predictor state
    logic [15:0]         cfg_start;
    logic [15:0]         cfg_safe;
    logic [15:0]         cfg_min;
    logic [15:0]         cfg_div;
    logic [15:0]         cfg_hold;
    phase_t              ramp_phase;
    logic [FIXED_W-1:0]  per_fx;
    logic [15:0]         hold_left;
    logic [15:0]         ticks_left;

    out_item_t           ramp_results_q[$];

    int errors;
    int n_in;
    int n_out;
    int n_comm;
    int n_hand;
    int n_give;
    int n_regs;
    int quiet;
    int rx_hold;
    bit idling;
    bit stall_request;

    typedef struct {
        bit          is_reg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        in_item_t    item;
        bit          typed;
        out_item_t   want;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic plan_row_t step_row(input logic [1:0] f, input logic rdy);
        plan_row_t r;
        r = '{0, CFG_START_PERIOD, 32'd0, '{f, rdy}, 0, '0};
        return r;
    endfunction

    function automatic plan_row_t checked_row(input logic [1:0] f, input logic rdy,
                                              input logic c, input logic [1:0] st,
                                              input logic [15:0] p);
        plan_row_t r;
        r = '{0, CFG_START_PERIOD, 32'd0, '{f, rdy}, 1, '{c, st, p}};
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [31:0] v);
        plan_row_t r;
        r = '{1, idx, v, '0, 0, '0};
        return r;
    endfunction

    function automatic logic [1:0] ramp_decide(input logic ready);
        logic [FIXED_W-1:0] safe_fx;
        logic [FIXED_W-1:0] dv;
        safe_fx = FIXED_W'(cfg_safe) << FRAC_BITS;
        dv = (cfg_div == 16'd0) ? FIXED_W'(1) : FIXED_W'(cfg_div);
        if (ready && per_fx < safe_fx) begin
            ramp_phase = PH_IDLE;
            return ST_HAND;
        end
        per_fx = per_fx - per_fx / dv;
        if ((per_fx >> FRAC_BITS) <= FIXED_W'(cfg_min)) begin
            per_fx = FIXED_W'(cfg_min) << FRAC_BITS;
            if (hold_left != 16'd0) begin
                hold_left = hold_left - 16'd1;
                return ST_CONT;
            end
            ramp_phase = PH_IDLE;
            return ST_GIVE;
        end
        return ST_CONT;
    endfunction

    function automatic out_item_t ramp_step(input in_item_t it);
        out_item_t r;
        r = '0;
        case (it.func)
            FUNC_START: begin
                per_fx = FIXED_W'(cfg_start) << FRAC_BITS;
                hold_left = cfg_hold;
                ticks_left = 16'(per_fx >> FRAC_BITS);
                ramp_phase = PH_RUN;
            end
            FUNC_STOP: begin
                ramp_phase = PH_IDLE;
            end
            FUNC_TICK: begin
                if (ramp_phase == PH_RUN) begin
                    if (ticks_left <= 16'd1) begin
                        r.commutate = 1'b1;
                        ticks_left = 16'(per_fx >> FRAC_BITS);
                        r.status = ramp_decide(it.spin_ready);
                    end else begin
                        ticks_left = ticks_left - 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.period_now = 16'(per_fx >> FRAC_BITS);
        return r;
    endfunction

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t pred;
        @(negedge aclk);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = ramp_step(it);
        ramp_results_q.push_back(typed ? want : pred);
        n_in++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_START_PERIOD:  cfg_start = v[15:0];
            CFG_SAFE_PERIOD:   cfg_safe  = v[15:0];
            CFG_MIN_PERIOD:    cfg_min   = v[15:0];
            CFG_DECAY_DIVISOR: cfg_div   = v[15:0];
            CFG_HOLD_COUNT:    cfg_hold  = v[15:0];
            default: begin
            end
        endcase
        n_regs++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (ramp_results_q.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random hold-offs plus one long stall on request
    initial begin
        m_ready = 1'b0;
        rx_hold = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (stall_request) begin
                stall_request = 0;
                rx_hold = LONG_STALL - 1;
                m_ready <= 1'b0;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                rx_hold = $urandom_range(1, 19) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_out++;
            if (m_data.commutate)
                n_comm++;
            if (m_data.status == ST_HAND)
                n_hand++;
            if (m_data.status == ST_GIVE)
                n_give++;
            if (ramp_results_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer %p", $time, m_data);
            end else begin
                want = ramp_results_q.pop_front();
                if (m_data.commutate !== want.commutate) begin
                    errors++;
                    $display("%0t: commutate exp %0b got %0b", $time,
                             want.commutate, m_data.commutate);
                end
                if (m_data.status !== want.status) begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time,
                             want.status, m_data.status);
                end
                if (m_data.period_now !== want.period_now) begin
                    errors++;
                    $display("%0t: period_now exp %0d got %0d", $time,
                             want.period_now, m_data.period_now);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet, ramp_results_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        in_item_t   it;
        int         useful;
        int         r;
        logic [15:0] v[5];

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        errors  = 0;
        n_in    = 0;
        n_out   = 0;
        n_comm  = 0;
        n_hand  = 0;
        n_give  = 0;
        n_regs  = 0;
        quiet   = 0;
        idling  = 1;
        stall_request = 0;

        cfg_start  = 16'd1000;
        cfg_safe   = 16'd100;
        cfg_min    = 16'd20;
        cfg_div    = 16'd64;
        cfg_hold   = 16'd0;
        ramp_phase = PH_IDLE;
        per_fx     = '0;
        hold_left  = '0;
        ticks_left = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: idle ticks, unused code, stop, start and restart
        plan.push_back(checked_row(FUNC_TICK,  1'b0, 1'b0, ST_NONE, 16'd0));
        plan.push_back(checked_row(FUNC_RSVD,  1'b1, 1'b0, ST_NONE, 16'd0));
        plan.push_back(checked_row(FUNC_STOP,  1'b0, 1'b0, ST_NONE, 16'd0));
        plan.push_back(checked_row(FUNC_START, 1'b0, 1'b0, ST_NONE, 16'd1000));
        plan.push_back(step_row(FUNC_TICK, 1'b1));
        plan.push_back(checked_row(FUNC_START, 1'b1, 1'b0, ST_NONE, 16'd1000));
        plan.push_back(checked_row(FUNC_STOP,  1'b1, 1'b0, ST_NONE, 16'd1000));
        plan.push_back(step_row(FUNC_TICK, 1'b1));
        // tiny period, zero divisor: hand off, then give up
        plan.push_back(reg_row(CFG_START_PERIOD,  32'hABCD_0002));
        plan.push_back(reg_row(CFG_SAFE_PERIOD,   32'h0000_FFFF));
        plan.push_back(reg_row(CFG_MIN_PERIOD,    32'h0000_0000));
        plan.push_back(reg_row(CFG_DECAY_DIVISOR, 32'hFFFF_0000));
        plan.push_back(reg_row(CFG_HOLD_COUNT,    32'h0000_0000));
        plan.push_back(reg_row(CFG_UNUSED,        32'hFFFF_FFFF));
        plan.push_back(step_row(FUNC_START, 1'b1));
        plan.push_back(step_row(FUNC_TICK, 1'b1));
        plan.push_back(checked_row(FUNC_TICK, 1'b1, 1'b1, ST_HAND, 16'd2));
        plan.push_back(step_row(FUNC_TICK, 1'b0));
        plan.push_back(step_row(FUNC_START, 1'b0));
        plan.push_back(step_row(FUNC_TICK, 1'b0));
        plan.push_back(checked_row(FUNC_TICK, 1'b0, 1'b1, ST_GIVE, 16'd0));
        // zero period with max clamp and hold budget
        plan.push_back(reg_row(CFG_START_PERIOD,  32'd0));
        plan.push_back(reg_row(CFG_SAFE_PERIOD,   32'd0));
        plan.push_back(reg_row(CFG_MIN_PERIOD,    32'h0000_FFFF));
        plan.push_back(reg_row(CFG_DECAY_DIVISOR, 32'h0000_FFFF));
        plan.push_back(reg_row(CFG_HOLD_COUNT,    32'd2));
        plan.push_back(checked_row(FUNC_START, 1'b0, 1'b0, ST_NONE, 16'd0));
        plan.push_back(checked_row(FUNC_TICK,  1'b1, 1'b1, ST_CONT, 16'hFFFF));
        plan.push_back(step_row(FUNC_TICK, 1'b0));
        plan.push_back(step_row(FUNC_TICK, 1'b1));
        // longest start period
        plan.push_back(reg_row(CFG_START_PERIOD, 32'h0000_FFFF));
        plan.push_back(checked_row(FUNC_START, 1'b1, 1'b0, ST_NONE, 16'hFFFF));
        plan.push_back(step_row(FUNC_TICK, 1'b1));
        plan.push_back(step_row(FUNC_STOP, 1'b0));

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            idling = (ph % 3 != 2) && (ph < N_PHASES - 2);
            if (ph == 0) begin
                foreach (v[k])
                    v[k] = 16'($urandom());
            end else if (ph == 1) begin
                v = '{16'd1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
            end else begin
                v[0] = 16'($urandom_range(0, 60));
                v[1] = 16'($urandom_range(0, 70));
                v[2] = 16'($urandom_range(0, 25));
                v[3] = 16'($urandom_range(0, 12));
                v[4] = 16'($urandom_range(0, 6));
            end
            write_reg(CFG_START_PERIOD,  {16'($urandom()), v[0]});
            write_reg(CFG_SAFE_PERIOD,   {16'($urandom()), v[1]});
            write_reg(CFG_MIN_PERIOD,    {16'($urandom()), v[2]});
            write_reg(CFG_DECAY_DIVISOR, {16'($urandom()), v[3]});
            write_reg(CFG_HOLD_COUNT,    {16'($urandom()), v[4]});
            if (ph == 5)
                write_reg(3'($urandom_range(5, 7)), $urandom());

            useful = 0;
            while (useful < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (ramp_phase == PH_IDLE)
                    it.func = (r < 70) ? FUNC_START : (r < 85) ? FUNC_TICK :
                              (r < 93) ? FUNC_STOP : FUNC_RSVD;
                else
                    it.func = (r < 90) ? FUNC_TICK : (r < 94) ? FUNC_STOP :
                              (r < 97) ? FUNC_START : FUNC_RSVD;
                it.spin_ready = ($urandom_range(0, 9) < 3);
                if (it.func == FUNC_START || (ramp_phase == PH_RUN &&
                    (it.func == FUNC_TICK || it.func == FUNC_STOP)))
                    useful++;
                if (ph == 4 && useful == 40)
                    stall_request = 1;
                send_item(it, 0, '0);
            end
        end

        drain();
        $display("ramp run: %0d transfers in, %0d out, %0d register writes",
                 n_in, n_out, n_regs);
        $display("  %0d commutations, %0d hand-offs, %0d give-ups, %0d errors",
                 n_comm, n_hand, n_give, errors);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
